// File: design/htu_pkg.sv
// Shared types, constants and helpers for the homogeneous transform unit.
// Used by every module of the block; no dependencies of its own.
package htu_pkg;

  localparam int CoefFracBits = 12;
  localparam int DataFracBits = 16;
  localparam int NumRegs      = 8;
  localparam int RegIdxW      = 3;

  typedef enum logic [2:0] {
    CMD_POINT   = 3'd0,
    CMD_VECTOR  = 3'd1,
    CMD_NORMAL  = 3'd2,
    CMD_IPOINT  = 3'd3,
    CMD_IVECTOR = 3'd4,
    CMD_BOX     = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    FLT_OK   = 2'd0,
    FLT_ZERO = 2'd1,
    FLT_SAT  = 2'd2
  } fault_e;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] rz;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic [1:0]         fault;
  } out_item_t;

  // Classified job handed from the front to the back.
  typedef struct packed {
    logic [2:0]         command;
    logic               valid_cmd;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] az;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
  } job_t;

  localparam logic [63:0] RegReset [NumRegs] = '{
    64'd4096, 64'd268435456, 64'd17592186044416, 64'd1152921504606846976,
    64'd4096, 64'd268435456, 64'd17592186044416, 64'd1152921504606846976
  };

endpackage

// File: design/htu_front.sv
// Front part: takes input beats, classifies the command, feeds a short queue.
// Depends on htu_pkg.
module htu_front #(
  parameter int Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  htu_pkg::in_item_t in_data_i,
  output logic              job_valid_o,
  input  logic              job_pop_i,
  output htu_pkg::job_t     job_o
);
  import htu_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic            push, pop;
  job_t            job_in;

  always_comb begin
    job_in.command   = in_data_i.command;
    job_in.valid_cmd = (in_data_i.command <= 3'(CMD_BOX));
    job_in.ax = in_data_i.ax;
    job_in.ay = in_data_i.ay;
    job_in.az = in_data_i.az;
    job_in.bx = in_data_i.bx;
    job_in.by = in_data_i.by;
    job_in.bz = in_data_i.bz;
  end

  assign in_stall_o  = (cnt_q == (PtrW+1)'(Depth));
  assign push        = in_valid_i && !in_stall_o;
  assign pop         = job_pop_i && job_valid_o;
  assign job_valid_o = (cnt_q != '0);
  assign job_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= job_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(Depth)) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == (PtrW+1)'(Depth)) |-> !push) else $error("push while full");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != '0) else $error("pop while empty");

endmodule

// File: design/htu_back.sv
// Back part: sequenced datapath with one shared MAC multiplier, three squarers, a
// bit-serial divider and a bit-serial square root. Depends on htu_pkg.
module htu_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [63:0]        regs_i [htu_pkg::NumRegs],
  input  logic               job_valid_i,
  output logic               job_pop_o,
  input  htu_pkg::job_t      job_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output htu_pkg::out_item_t out_data_o
);
  import htu_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MAC  = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_NORM = 8'b0000_1000,
    S_SQRT = 8'b0001_0000,
    S_NDIV = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  job_t               job_q;
  logic [2:0]         corner_q;
  logic [3:0]         mac_q;      // {row, col} step
  logic signed [63:0] acc_q [4];
  logic [1:0]         axis_q;
  logic [6:0]         bit_q;
  logic [63:0]        num_q, den_q, rem_q, quo_q;
  logic               zero_w_q, sat_q;
  logic signed [31:0] r_q [3], s_q [3];
  logic [63:0]        m_q [3];
  logic [63:0]        sum_q, sroot_q, sbit_q;
  out_item_t          out_q;
  logic               out_valid_q;

  logic               is_box, is_point, is_vec, mat_inv;
  logic [1:0]         row, col;
  logic signed [15:0] cf;
  logic signed [31:0] pv [3];
  logic signed [31:0] opnd;
  logic signed [47:0] prod;

  assign is_box   = (job_q.command == 3'(CMD_BOX));
  assign is_point = (job_q.command == 3'(CMD_POINT)) ||
                    (job_q.command == 3'(CMD_IPOINT)) || is_box;
  assign is_vec   = (job_q.command == 3'(CMD_VECTOR)) ||
                    (job_q.command == 3'(CMD_IVECTOR));
  assign mat_inv  = (job_q.command == 3'(CMD_IPOINT)) ||
                    (job_q.command == 3'(CMD_IVECTOR)) ||
                    (job_q.command == 3'(CMD_NORMAL));
  assign row = mac_q[3:2];
  assign col = mac_q[1:0];

  // Box corner selects per axis; other commands use the a corner.
  assign pv[0] = (is_box && corner_q[0]) ? job_q.bx : job_q.ax;
  assign pv[1] = (is_box && corner_q[1]) ? job_q.by : job_q.ay;
  assign pv[2] = (is_box && corner_q[2]) ? job_q.bz : job_q.az;

  // Normal form uses the transposed inverse: output row i takes coef(j,i).
  always_comb begin
    if (job_q.command == 3'(CMD_NORMAL))
      cf = regs_i[{1'b1, col}][16*row +: 16];
    else
      cf = regs_i[{mat_inv, row}][16*col +: 16];
    opnd = (col == 2'd3) ? (32'sd1 <<< DataFracBits) : pv[col];
  end
  assign prod = 48'(cf) * 48'(opnd);

  // Divider signs and per-axis helpers.
  logic [63:0] mag_acc, mag_w;
  logic        neg_q;
  logic [64:0] rem_sh;
  logic [63:0] rem_nx, quo_nx;
  logic [63:0] mx;
  logic [63:0] trial;
  logic [59:0] sq [3];

  assign mag_acc = acc_q[axis_q][63] ? 64'(-acc_q[axis_q]) : 64'(acc_q[axis_q]);
  assign mag_w   = acc_q[3][63] ? 64'(-acc_q[3]) : 64'(acc_q[3]);
  assign rem_sh  = {rem_q, num_q[63]};
  assign mx = (m_q[0] > m_q[1]) ? ((m_q[0] > m_q[2]) ? m_q[0] : m_q[2])
                                : ((m_q[1] > m_q[2]) ? m_q[1] : m_q[2]);
  assign trial = sroot_q + sbit_q;

  // One restoring divide step.
  always_comb begin
    if (rem_sh >= {1'b0, den_q}) begin
      rem_nx = 64'(rem_sh - {1'b0, den_q});
      quo_nx = {quo_q[62:0], 1'b1};
    end else begin
      rem_nx = rem_sh[63:0];
      quo_nx = {quo_q[62:0], 1'b0};
    end
  end

  // Magnitudes are below 2^30 once normalized.
  always_comb begin
    for (int i = 0; i < 3; i++) sq[i] = m_q[i][29:0] * m_q[i][29:0];
  end

  // Quotient finish on the last divide step, including its final bit.
  logic        qsat;
  logic signed [31:0] qval;
  always_comb begin
    qsat = neg_q ? (quo_nx > 64'h8000_0000) : (quo_nx > 64'h7fff_ffff);
    qval = qsat ? (neg_q ? 32'h80000000 : 32'h7fffffff)
                : (neg_q ? 32'(-quo_nx) : quo_nx[31:0]);
  end

  function automatic logic signed [31:0] vr(input logic signed [63:0] a);
    logic signed [63:0] t;
    t = (a + (64'sd1 <<< (CoefFracBits - 1))) >>> CoefFracBits;
    if (t > 64'sd2147483647) return 32'h7fffffff;
    if (t < -64'sd2147483648) return 32'h80000000;
    return t[31:0];
  endfunction

  function automatic logic vs(input logic signed [63:0] a);
    logic signed [63:0] t;
    t = (a + (64'sd1 <<< (CoefFracBits - 1))) >>> CoefFracBits;
    return (t > 64'sd2147483647) || (t < -64'sd2147483648);
  endfunction

  // Result beat assembled from the finished job.
  out_item_t fin_d;
  always_comb begin
    fin_d.rx = r_q[0]; fin_d.ry = r_q[1]; fin_d.rz = r_q[2];
    fin_d.sx = s_q[0]; fin_d.sy = s_q[1]; fin_d.sz = s_q[2];
    fin_d.fault = 2'(FLT_OK);
    if (is_vec) begin
      // vector results are rounded and clamped here, axis by axis
      fin_d.rx = vr(acc_q[0]); fin_d.ry = vr(acc_q[1]);
      fin_d.rz = vr(acc_q[2]);
      if (vs(acc_q[0]) || vs(acc_q[1]) || vs(acc_q[2]))
        fin_d.fault = 2'(FLT_SAT);
    end else if (zero_w_q) begin
      fin_d = '0;
      fin_d.fault = 2'(FLT_ZERO);
    end else if (sat_q) begin
      fin_d.fault = 2'(FLT_SAT);
    end
    if (!job_q.valid_cmd) begin
      fin_d = '0;
    end
  end

  assign job_pop_o   = (state_q == S_IDLE) && job_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (job_valid_i) state_d = S_MAC;
      S_MAC:  if (mac_q == 4'hf || (job_q.command == 3'(CMD_NORMAL) && mac_q == 4'hb)
                  || (is_vec && mac_q == 4'hb))
                state_d = !job_q.valid_cmd ? S_FIN : is_point ? S_DIV :
                          is_vec ? S_FIN : S_NORM;
      S_DIV:  ;
      S_NORM: ;
      S_SQRT: ;
      S_NDIV: ;
      S_FIN:  if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_FIN && (!out_valid_q || !out_stall_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: state_q <= state_d;
        S_MAC:  state_q <= state_d;
        S_DIV: begin
          if (mag_w == 0) begin
            state_q <= (is_box && corner_q != 3'd7) ? S_MAC : S_FIN;
          end else if (bit_q == 7'd0 && axis_q == 2'd2) begin
            state_q <= (is_box && corner_q != 3'd7) ? S_MAC : S_FIN;
          end
        end
        S_NORM: if (mx == 0) state_q <= S_FIN;
                else if (mx[63:29] == 35'd1) state_q <= S_SQRT;
        S_SQRT: if (sbit_q == 0) state_q <= S_NDIV;
        S_NDIV: if (bit_q == 7'd0 && axis_q == 2'd2) state_q <= S_FIN;
        S_FIN:  if (!out_valid_q || !out_stall_i) state_q <= S_IDLE;
        S_OUT: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (job_valid_i) begin
        job_q    <= job_i;
        corner_q <= 3'd0;
        mac_q    <= 4'd0;
        zero_w_q <= 1'b0;
        sat_q    <= 1'b0;
        for (int i = 0; i < 4; i++) acc_q[i] <= '0;
        for (int i = 0; i < 3; i++) begin r_q[i] <= '0; s_q[i] <= '0; end
      end
      S_MAC: begin
        if (col == 2'd3 && !is_point) begin
          mac_q <= mac_q + 4'd1;
        end else begin
          acc_q[row] <= acc_q[row] + 64'(prod);
          mac_q <= mac_q + 4'd1;
        end
        if (state_d == S_DIV) begin
          axis_q <= 2'd0;
          bit_q  <= 7'd64;
          rem_q  <= '0;
          quo_q  <= '0;
        end
        if (state_d == S_NORM) begin
          for (int i = 0; i < 3; i++)
            m_q[i] <= acc_q[i][63] ? 64'(-acc_q[i]) : 64'(acc_q[i]);
        end
        if (state_d == S_FIN && is_vec) begin
          axis_q <= 2'd0;
        end
      end
      S_DIV: begin
        if (mag_w == 0) begin
          zero_w_q <= 1'b1;
          corner_q <= corner_q + 3'd1;
          mac_q    <= 4'd0;
          for (int i = 0; i < 4; i++) acc_q[i] <= '0;
        end else if (bit_q == 7'd64) begin
          // load: |acc| stays below 2^48, so |acc| << 16 fits in 64 bits
          num_q <= mag_acc << DataFracBits;
          den_q <= mag_w;
          neg_q <= acc_q[axis_q][63] ^ acc_q[3][63];
          rem_q <= '0;
          quo_q <= '0;
          bit_q <= 7'd63;
        end else begin
          num_q <= num_q << 1;
          rem_q <= rem_nx;
          quo_q <= quo_nx;
          if (bit_q == 7'd0) begin
            if (qsat) sat_q <= 1'b1;
            if (!is_box) r_q[axis_q] <= qval;
            else begin
              if (corner_q == 3'd0 || qval < r_q[axis_q]) r_q[axis_q] <= qval;
              if (corner_q == 3'd0 || qval > s_q[axis_q]) s_q[axis_q] <= qval;
            end
            bit_q <= 7'd64;
            if (axis_q == 2'd2) begin
              axis_q   <= 2'd0;
              corner_q <= corner_q + 3'd1;
              mac_q    <= 4'd0;
              for (int i = 0; i < 4; i++) acc_q[i] <= '0;
            end else begin
              axis_q <= axis_q + 2'd1;
            end
          end else begin
            bit_q <= bit_q - 7'd1;
          end
        end
      end
      S_NORM: begin
        if (mx != 0) begin
          if (mx >= 64'h4000_0000) begin
            for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
          end else if (mx < 64'h2000_0000) begin
            for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
          end else begin
            sum_q   <= 64'(sq[0]) + 64'(sq[1]) + 64'(sq[2]);
            sroot_q <= '0;
            sbit_q  <= 64'h4000_0000_0000_0000;
          end
        end
      end
      S_SQRT: begin
        if (sbit_q != 0) begin
          if (sum_q >= trial) begin
            sum_q   <= sum_q - trial;
            sroot_q <= (sroot_q >> 1) + sbit_q;
          end else begin
            sroot_q <= sroot_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
        end else begin
          axis_q <= 2'd0;
          bit_q  <= 7'd64;
        end
      end
      S_NDIV: begin
        if (bit_q == 7'd64) begin
          num_q <= m_q[axis_q] << DataFracBits;
          den_q <= sroot_q;
          neg_q <= acc_q[axis_q][63];
          rem_q <= '0;
          quo_q <= '0;
          bit_q <= 7'd63;
        end else begin
          num_q <= num_q << 1;
          rem_q <= rem_nx;
          quo_q <= quo_nx;
          if (bit_q == 7'd0) begin
            r_q[axis_q] <= qval;
            bit_q <= 7'd64;
            axis_q <= axis_q + 2'd1;
          end else begin
            bit_q <= bit_q - 7'd1;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_q <= fin_d;
        end
      end
      default: ;
    endcase
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |=> state_q == S_MAC) else $error("pop without start");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q) else $error("result dropped");

endmodule

// File: design/homogeneous_transform_unit.sv
// Homogeneous 4x4 transform unit.
// Channels: input beats (in_valid_i / in_stall_o, in_data_i), result beats
// (out_valid_o / out_stall_i, out_data_o), and a register write channel
// (cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i) for the forward rows
// (index 0..3) and inverse rows (index 4..7), four Q4.12 values per row.
// Writes beyond index 7 are ignored. Write registers only while idle.
// A two-entry queue sits between the front and the sequenced back, so a new
// beat is taken while the back still works and while a result waits.
// A vector takes 12 multiply steps. A point takes 16 multiply steps, then a
// load and a bit-serial divide per axis; a box repeats that sequence for each
// of its eight corners. A normal takes 12 multiply steps, a normalize loop, a
// square root and a divide per axis. The back runs one item at a time and
// takes the next job in the idle state entered after a result is loaded;
// the bit-serial divider sets the throughput of points, boxes and normals.
// Reset loads the identity into both matrices and empties the queue.
// When the receiver stalls, the result holds and the back waits; the queue
// then fills and in_stall_o rises.
module homogeneous_transform_unit #(
  parameter int QueueDepth = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  htu_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output htu_pkg::out_item_t           out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [htu_pkg::RegIdxW-1:0]  cfg_index_i,
  input  logic [63:0]                  cfg_data_i
);
  import htu_pkg::*;

  logic [63:0] regs_q [NumRegs];
  logic        job_valid, job_pop;
  job_t        job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) regs_q[i] <= RegReset[i];
    end else if (cfg_valid_i) begin
      regs_q[cfg_index_i] <= cfg_data_i;
    end
  end

  htu_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .job_valid_o(job_valid), .job_pop_i(job_pop), .job_o(job)
  );

  htu_back u_back (
    .clk_i, .rst_ni, .regs_i(regs_q),
    .job_valid_i(job_valid), .job_pop_o(job_pop), .job_i(job),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule
